>>> src/aacdp_pkg.sv
`default_nettype none

package aacdp_pkg;

  // Most AU headers whose sizes are kept per packet
  localparam int unsigned MAX_AUS_DEFAULT = 32;
  // AU size field of one AU header
  localparam int unsigned AU_SIZE_W = 13;

  // Result error codes
  localparam logic [1:0] ERR_NONE    = 2'd0;
  localparam logic [1:0] ERR_HDR_LEN = 2'd1;
  localparam logic [1:0] ERR_SHORT   = 2'd2;
  localparam logic [1:0] ERR_TRUNC   = 2'd3;

  typedef struct packed {
    logic [7:0] payload_byte;
    logic       packet_end;
    logic       marker_bit;
  } in_item_t;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       byte_valid;
    logic       frame_end;
    logic [1:0] error_code;
    logic       run_last;
  } out_item_t;

  // Controller to datapath
  typedef struct packed {
    logic load;   // latch the accepted beat
    logic exec;   // run the per-phase step on the latched beat
    logic rd;     // read the size store at au_index
    logic no_au;  // no AU left: drop into padding
    logic chk;    // act on the size just read
    logic fin;    // packet-end check and packet state clear
    logic flush;  // hand the held result out as the last of the beat
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic can_emit;
    logic slot_free;
    logic hold_valid;
    logic exec_scan;
    logic au_avail;
    logic au_zero;
  } status_t;

endpackage

`default_nettype wire

>>> src/aacdp_ram.sv
`default_nettype none

module aacdp_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 32,
  parameter int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic             re,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

>>> src/aacdp_ctrl.sv
`default_nettype none

module aacdp_ctrl
  import aacdp_pkg::*;
(
  input  wire logic    clk,
  input  wire logic    rst,
  input  wire logic    payload_valid,
  output logic         payload_stall,
  input  wire status_t status,
  output cmd_t         cmd
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_EXEC,
    S_RD,
    S_CHK,
    S_FIN,
    S_FLUSH
  } state_t;

  state_t state, state_next;

  always_comb begin
    cmd        = '0;
    state_next = state;
    case (state)
      S_IDLE: begin
        if (payload_valid) begin
          cmd.load   = 1'b1;
          state_next = S_EXEC;
        end
      end
      S_EXEC: begin
        if (status.can_emit) begin
          cmd.exec   = 1'b1;
          state_next = status.exec_scan ? S_RD : S_FIN;
        end
      end
      S_RD: begin
        if (status.au_avail) begin
          cmd.rd     = 1'b1;
          state_next = S_CHK;
        end else begin
          cmd.no_au  = 1'b1;
          state_next = S_FIN;
        end
      end
      S_CHK: begin
        if (status.can_emit) begin
          cmd.chk    = 1'b1;
          state_next = status.au_zero ? S_RD : S_FIN;
        end
      end
      S_FIN: begin
        if (status.can_emit) begin
          cmd.fin    = 1'b1;
          state_next = S_FLUSH;
        end
      end
      S_FLUSH: begin
        if (!status.hold_valid) begin
          state_next = S_IDLE;
        end else if (status.slot_free) begin
          cmd.flush  = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      payload_stall <= 1'b0;
    end else begin
      state         <= state_next;
      payload_stall <= (state_next != S_IDLE);
    end
  end

endmodule

`default_nettype wire

>>> src/aacdp_dpath.sv
`default_nettype none

module aacdp_dpath
  import aacdp_pkg::*;
#(
  parameter int unsigned MAX_AUS = MAX_AUS_DEFAULT
) (
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire cmd_t      cmd,
  output status_t        status,
  input  wire in_item_t  payload,
  output logic           au_valid,
  input  wire logic      au_stall,
  output out_item_t      au_result
);

  localparam int unsigned AW = (MAX_AUS > 1) ? $clog2(MAX_AUS) : 1;
  localparam int unsigned CW = $clog2(MAX_AUS + 1);

  typedef enum logic [2:0] {
    PH_LEN_HI,
    PH_LEN_LO,
    PH_HDR,
    PH_DATA,
    PH_SKIP,
    PH_BADHDR
  } phase_t;

  in_item_t  in_q;
  logic      closing;
  phase_t    phase;
  logic [7:0]  length_high;
  logic [13:0] header_bytes;
  logic [15:0] byte_position;
  logic [CW-1:0] au_count;
  logic [CW-1:0] au_index;
  logic [AU_SIZE_W-1:0] bytes_left;
  logic      packet_error;

  out_item_t hold;
  logic      hold_valid;
  out_item_t push_res;

  logic [16:0] len_sum;
  logic [13:0] hb_new;
  logic [12:0] hb_half;
  logic [CW-1:0] count_new;
  logic [15:0] hdr_off;
  logic [14:0] hdr_k;
  logic        hdr_last;
  logic [AU_SIZE_W-1:0] bl_dec;
  logic        fin_err;
  logic        emit_req;
  out_item_t   emit_res;
  logic        slot_free;
  logic        push;

  logic                 ram_we;
  logic [AW-1:0]        ram_waddr;
  logic [AU_SIZE_W-1:0] ram_wdata;
  logic [AU_SIZE_W-1:0] ram_rdata;

  // Length in bits, rounded up to whole bytes
  assign len_sum = {1'b0, length_high, in_q.payload_byte} + 17'd7;
  assign hb_new  = len_sum[16:3];
  assign hb_half = hb_new[13:1];

  always_comb begin
    if (hb_half < 13'(MAX_AUS)) begin
      count_new = hb_half[CW-1:0];
    end else begin
      count_new = CW'(MAX_AUS);
    end
  end

  assign hdr_off  = byte_position - 16'd2;
  assign hdr_k    = hdr_off[15:1];
  assign hdr_last = (byte_position - 16'd1) >= {2'b00, header_bytes};
  assign bl_dec   = bytes_left - 13'd1;

  assign ram_we    = cmd.exec && (phase == PH_HDR) && hdr_off[0]
                     && (hdr_k < 15'(MAX_AUS));
  assign ram_waddr = hdr_k[AW-1:0];
  assign ram_wdata = {length_high, in_q.payload_byte[7:3]};

  aacdp_ram #(
    .WIDTH (AU_SIZE_W),
    .DEPTH (MAX_AUS),
    .AW    (AW)
  ) u_size_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (cmd.rd),
    .raddr (au_index[AW-1:0]),
    .rdata (ram_rdata)
  );

  assign fin_err = in_q.packet_end && !packet_error
                   && ((phase == PH_LEN_LO) || (phase == PH_HDR)
                       || (phase == PH_BADHDR) || (phase == PH_DATA));

  // Result produced by the current command, if any
  always_comb begin
    emit_req = 1'b0;
    emit_res = '0;
    if (cmd.exec) begin
      case (phase)
        PH_DATA: begin
          emit_req           = 1'b1;
          emit_res.data_byte  = in_q.payload_byte;
          emit_res.byte_valid = 1'b1;
          emit_res.frame_end  = (bl_dec == '0) && closing;
        end
        PH_BADHDR: begin
          if (byte_position >= 16'd3) begin
            emit_req            = 1'b1;
            emit_res.error_code = ERR_HDR_LEN;
          end
        end
        default: begin
          emit_req = 1'b0;
        end
      endcase
    end
    if (cmd.chk && (ram_rdata == '0) && closing) begin
      emit_req           = 1'b1;
      emit_res.frame_end = 1'b1;
    end
    if (cmd.fin && fin_err) begin
      emit_req            = 1'b1;
      emit_res.error_code = (phase == PH_DATA) ? ERR_TRUNC : ERR_SHORT;
    end
  end

  assign slot_free = !au_valid || !au_stall;
  assign push      = hold_valid && (emit_req || cmd.flush);

  // Mark the held result as last when it leaves on a flush
  always_comb begin
    push_res          = hold;
    push_res.run_last = cmd.flush;
  end

  assign status.can_emit   = !hold_valid || slot_free;
  assign status.slot_free  = slot_free;
  assign status.hold_valid = hold_valid;
  assign status.exec_scan  = ((phase == PH_HDR) && hdr_last)
                             || ((phase == PH_DATA) && (bl_dec == '0));
  assign status.au_avail   = au_index < au_count;
  assign status.au_zero    = (ram_rdata == '0);

  // Hold one result back so the last of a beat can be marked
  always_ff @(posedge clk) begin
    if (rst) begin
      au_valid   <= 1'b0;
      hold_valid <= 1'b0;
    end else begin
      if (push) begin
        au_valid <= 1'b1;
      end else if (!au_stall) begin
        au_valid <= 1'b0;
      end
      if (emit_req) begin
        hold_valid <= 1'b1;
      end else if (cmd.flush) begin
        hold_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      au_result <= push_res;
    end
    if (emit_req) begin
      hold <= emit_res;
    end
    if (cmd.load) begin
      in_q    <= payload;
      closing <= (header_bytes >= 14'd4) || payload.marker_bit;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= PH_LEN_HI;
      length_high   <= '0;
      header_bytes  <= '0;
      byte_position <= '0;
      au_count      <= '0;
      au_index      <= '0;
      bytes_left    <= '0;
      packet_error  <= 1'b0;
    end else begin
      if (cmd.exec) begin
        case (phase)
          PH_LEN_HI: begin
            length_high <= in_q.payload_byte;
            phase       <= PH_LEN_LO;
          end
          PH_LEN_LO: begin
            header_bytes <= hb_new;
            if (hb_new < 14'd2) begin
              phase <= PH_BADHDR;
            end else begin
              au_count <= count_new;
              au_index <= '0;
              phase    <= PH_HDR;
            end
          end
          PH_HDR: begin
            if (!hdr_off[0]) begin
              length_high <= in_q.payload_byte;
            end
            if (hdr_last) begin
              au_index <= '0;
            end
          end
          PH_DATA: begin
            bytes_left <= bl_dec;
            if (bl_dec == '0) begin
              au_index <= au_index + CW'(1);
            end
          end
          PH_BADHDR: begin
            if (byte_position >= 16'd3) begin
              packet_error <= 1'b1;
              phase        <= PH_SKIP;
            end
          end
          default: begin
            phase <= phase;
          end
        endcase
        if (byte_position != 16'hFFFF) begin
          byte_position <= byte_position + 16'd1;
        end
      end
      if (cmd.no_au) begin
        bytes_left <= '0;
        phase      <= PH_SKIP;
      end
      if (cmd.chk) begin
        if (ram_rdata == '0) begin
          au_index <= au_index + CW'(1);
        end else begin
          bytes_left <= ram_rdata;
          phase      <= PH_DATA;
        end
      end
      if (cmd.fin && in_q.packet_end) begin
        phase         <= PH_LEN_HI;
        length_high   <= '0;
        header_bytes  <= '0;
        byte_position <= '0;
        au_count      <= '0;
        au_index      <= '0;
        bytes_left    <= '0;
        packet_error  <= 1'b0;
      end
    end
  end

endmodule

`default_nettype wire

>>> src/aac_au_depacketizer_core.sv
`default_nettype none

// Channel    Direction  Beat type    Handshake
// payload    in         in_item_t    payload_valid / payload_stall
// au_result  out        out_item_t   au_valid / au_stall
//
// One payload beat is taken at a time: accept, step, packet-end check and
// hand-off follow one another in that order.
// At the end of the AU headers or of an AU each size-store lookup adds a read
// and a check step (registered RAM read), one lookup per empty AU skipped plus
// one for the next non-empty AU; finding no AU left adds a read step only.
// Reset (rst, synchronous) clears the control state; the AU size store is not
// cleared, as every read hits an entry written in the same packet.
// A stall on au_result holds the controller wherever it would emit a result.

module aac_au_depacketizer_core
  import aacdp_pkg::*;
#(
  parameter int unsigned MAX_AUS = MAX_AUS_DEFAULT
) (
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire logic      payload_valid,
  output logic           payload_stall,
  input  wire in_item_t  payload,
  output logic           au_valid,
  input  wire logic      au_stall,
  output out_item_t      au_result
);

  cmd_t    cmd;
  status_t status;

  // Sequence the steps of one beat
  aacdp_ctrl u_ctrl (
    .clk           (clk),
    .rst           (rst),
    .payload_valid (payload_valid),
    .payload_stall (payload_stall),
    .status        (status),
    .cmd           (cmd)
  );

  // Hold packet state, the AU size store and the result registers
  aacdp_dpath #(
    .MAX_AUS (MAX_AUS)
  ) u_dpath (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .status    (status),
    .payload   (payload),
    .au_valid  (au_valid),
    .au_stall  (au_stall),
    .au_result (au_result)
  );

endmodule

`default_nettype wire
